// File: rtl/cth_pkg.sv
// ---------------------------------------------------------------------------
// cth_pkg - shared types for the countdown timer
// command and mode codes, the h/m/s time record and the 60-way split helper
// ---------------------------------------------------------------------------
package cth_pkg;

  localparam int unsigned TpsWidth   = 10;
  localparam int unsigned SubWidth   = 10;
  localparam int unsigned HoursWidth = 9;
  localparam int unsigned SexaWidth  = 6;
  localparam int unsigned InWidth    = 8;

  localparam logic [TpsWidth-1:0] TpsReset = TpsWidth'(1000);
  localparam logic [SexaWidth-1:0] SexaMax = SexaWidth'(59);

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_RUNNING  = 2'd1,
    MODE_PAUSED   = 2'd2,
    MODE_FINISHED = 2'd3
  } mode_e;

  typedef struct packed {
    logic [HoursWidth-1:0] hours;
    logic [SexaWidth-1:0]  minutes;
    logic [SexaWidth-1:0]  seconds;
  } hms_t;

  typedef struct packed {
    mode_e mode;
    hms_t  left;
  } result_t;

  typedef struct packed {
    logic [2:0]           quot;
    logic [SexaWidth-1:0] rem;
  } divmod60_t;

  // split a value below 300 into multiples of sixty and a remainder
  function automatic divmod60_t divmod60(input logic [HoursWidth-1:0] x);
    divmod60_t r;
    priority if (x >= HoursWidth'(240)) begin
      r.quot = 3'd4;
      r.rem  = SexaWidth'(x - HoursWidth'(240));
    end else if (x >= HoursWidth'(180)) begin
      r.quot = 3'd3;
      r.rem  = SexaWidth'(x - HoursWidth'(180));
    end else if (x >= HoursWidth'(120)) begin
      r.quot = 3'd2;
      r.rem  = SexaWidth'(x - HoursWidth'(120));
    end else if (x >= HoursWidth'(60)) begin
      r.quot = 3'd1;
      r.rem  = SexaWidth'(x - HoursWidth'(60));
    end else begin
      r.quot = 3'd0;
      r.rem  = SexaWidth'(x);
    end
    return r;
  endfunction

endpackage

// File: rtl/cth_core.sv
// ---------------------------------------------------------------------------
// cth_core - timer state and per-beat update
// holds mode, loaded and remaining time in h/m/s form, sub-second count and
// the ticks-per-second register; gives the post-update result combinationally
// ---------------------------------------------------------------------------
module cth_core import cth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TpsWidth-1:0]   cfg_wdata_i,
  input  logic                  accept_i,
  input  logic [2:0]            command_i,
  input  logic [InWidth-1:0]    start_hours_i,
  input  logic [InWidth-1:0]    start_minutes_i,
  input  logic [InWidth-1:0]    start_seconds_i,
  output result_t               result_o
);

  mode_e               mode_q, mode_d;
  hms_t                loaded_q, loaded_d;
  hms_t                remain_q, remain_d;
  logic [SubWidth-1:0] sub_q, sub_d;
  logic [TpsWidth-1:0] tps_q;

  logic [SubWidth:0]   sub_inc;
  logic                sec_done;
  hms_t                remain_dec;
  logic                dec_zero;
  hms_t                start_hms;
  logic                start_zero;
  divmod60_t           sec_split;
  divmod60_t           min_split;
  logic [HoursWidth-1:0] min_sum;

  // the extra bit keeps a count of 1023 from wrapping to 0, so it still ends the second
  assign sub_inc  = {1'b0, sub_q} + (SubWidth+1)'(1);
  assign sec_done = sub_inc >= {1'b0, tps_q};

  // one-second borrow chain, stays at zero
  always_comb begin
    remain_dec = remain_q;
    if (remain_q.seconds != '0) begin
      remain_dec.seconds = remain_q.seconds - SexaWidth'(1);
    end else if (remain_q.minutes != '0) begin
      remain_dec.minutes = remain_q.minutes - SexaWidth'(1);
      remain_dec.seconds = SexaMax;
    end else if (remain_q.hours != '0) begin
      remain_dec.hours   = remain_q.hours - HoursWidth'(1);
      remain_dec.minutes = SexaMax;
      remain_dec.seconds = SexaMax;
    end
  end

  assign dec_zero = (remain_dec == '0);

  // normalize start fields, minutes and seconds may exceed 59
  assign sec_split = divmod60({1'b0, start_seconds_i});
  assign min_sum   = {1'b0, start_minutes_i} + HoursWidth'(sec_split.quot);
  assign min_split = divmod60(min_sum);

  always_comb begin
    start_hms.hours   = {1'b0, start_hours_i} + HoursWidth'(min_split.quot);
    start_hms.minutes = min_split.rem;
    start_hms.seconds = sec_split.rem;
  end

  assign start_zero = (start_hms == '0);

  always_comb begin
    mode_d   = mode_q;
    loaded_d = loaded_q;
    remain_d = remain_q;
    sub_d    = sub_q;
    if (accept_i) begin
      unique case (command_i)
        CMD_TICK: begin
          if (mode_q == MODE_RUNNING) begin
            if (sec_done) begin
              sub_d    = '0;
              remain_d = remain_dec;
              if (dec_zero) begin
                mode_d = MODE_FINISHED;
              end
            end else begin
              sub_d = sub_inc[SubWidth-1:0];
            end
          end
        end
        CMD_START: begin
          loaded_d = start_hms;
          remain_d = start_hms;
          sub_d    = '0;
          mode_d   = start_zero ? MODE_FINISHED : MODE_RUNNING;
        end
        CMD_PAUSE: begin
          if (mode_q == MODE_RUNNING) begin
            mode_d = MODE_PAUSED;
          end
        end
        CMD_RESUME: begin
          if (mode_q == MODE_PAUSED) begin
            sub_d  = '0;
            mode_d = MODE_RUNNING;
          end
        end
        CMD_RESET: begin
          remain_d = loaded_q;
          sub_d    = '0;
          mode_d   = MODE_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      loaded_q <= '0;
      remain_q <= '0;
      sub_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      loaded_q <= loaded_d;
      remain_q <= remain_d;
      sub_q    <= sub_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
    end else if (cfg_we_i) begin
      tps_q <= cfg_wdata_i;
    end
  end

  assign result_o.mode = mode_d;
  assign result_o.left = remain_d;

  // running always has time left
  a_running_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_RUNNING |-> remain_q != '0)
    else $error("running with no time left");

  // reset restores the loaded time
  a_reset_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i == CMD_RESET |=> remain_q == loaded_q && mode_q == MODE_IDLE)
    else $error("reset did not reload the countdown");

  // a tick leaves the remaining time alone or takes off one second
  a_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && command_i == CMD_TICK |=> remain_q == $past(remain_q)
      || remain_q == $past(remain_dec))
    else $error("tick moved remaining time by more than one second");

endmodule

// File: rtl/countdown_timer_hms.sv
// ---------------------------------------------------------------------------
// countdown_timer_hms - command driven h/m/s countdown timer
// takes tick/start/pause/resume/reset beats and returns one status beat each
// ---------------------------------------------------------------------------
//   channel | handshake               | payload
//   --------+-------------------------+--------------------------------------
//   in      | in_valid_i / in_ready_o | command, start hours/minutes/seconds
//   out     | out_valid_o/out_ready_i | timer state, left hours/min/seconds
//   cfg     | cfg_we_i                | cfg_wdata_i = ticks per second
//
// one beat per cycle while in_ready_o is high; the result is registered and appears in the cycle after its input beat
// the only path is the state update into the output register
// in_ready_o is low only while a result waits and out_ready_i is low
// reset is asynchronous: mode idle, times zero, 1000 ticks per second
// ---------------------------------------------------------------------------
module countdown_timer_hms import cth_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [TpsWidth-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            command_i,
  input  logic [InWidth-1:0]    start_hours_i,
  input  logic [InWidth-1:0]    start_minutes_i,
  input  logic [InWidth-1:0]    start_seconds_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            timer_state_o,
  output logic [HoursWidth-1:0] left_hours_o,
  output logic [SexaWidth-1:0]  left_minutes_o,
  output logic [SexaWidth-1:0]  left_seconds_o
);

  logic    accept;
  result_t next_res;
  result_t res_q;
  logic    out_valid_q, out_valid_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  cth_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .command_i       (command_i),
    .start_hours_i   (start_hours_i),
    .start_minutes_i (start_minutes_i),
    .start_seconds_i (start_seconds_i),
    .result_o        (next_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= next_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign timer_state_o  = res_q.mode;
  assign left_hours_o   = res_q.left.hours;
  assign left_minutes_o = res_q.left.minutes;
  assign left_seconds_o = res_q.left.seconds;

  a_split_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_minutes_o < SexaWidth'(60) && left_seconds_o < SexaWidth'(60))
    else $error("minutes or seconds out of range");

  a_zero_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && command_i == CMD_START && start_hours_i == '0 && start_minutes_i == '0
      && start_seconds_i == '0 |=> timer_state_o == MODE_FINISHED)
    else $error("empty start did not finish");

endmodule
